// ----- rtl/periodic_task_tick_scheduler_unit_macros.svh -----
// assertion macros shared by the scheduler rtl
`ifndef PERIODIC_TASK_TICK_SCHEDULER_UNIT_MACROS_SVH
`define PERIODIC_TASK_TICK_SCHEDULER_UNIT_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define PTTSU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define PTTSU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pttsu_pkg.sv -----
// shared types and constants of the tick scheduler
package pttsu_pkg;

   localparam int OP_W     = 3;
   localparam int SLOT_W   = 6;
   localparam int REQ_SLOT_W = 8;
   localparam int DELAY_W  = 16;
   localparam int STAT_W   = 2;

   localparam logic [OP_W-1:0] OP_TICK   = 3'd0;
   localparam logic [OP_W-1:0] OP_CREATE = 3'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
   localparam logic [OP_W-1:0] OP_PLAY   = 3'd3;
   localparam logic [OP_W-1:0] OP_PAUSE  = 3'd4;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_SLOT  = 2'd2;

   // command class worked out by the front end
   typedef enum logic [2:0] {
      K_TICK,
      K_CREATE,
      K_DELETE,
      K_PLAY,
      K_PAUSE,
      K_NOP,
      K_RANGE
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type              kind;
      logic [SLOT_W-1:0]         slot;
      logic [DELAY_W-1:0]        first_delay;
      logic [DELAY_W-1:0]        period;
      logic                      start_running;
   } cmd_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_FLUSH,
      ST_CLOSE
   } state_type;

endpackage

// ----- rtl/pttsu_ram.sv -----
// generic single write port ram with registered read
module pttsu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ----- rtl/pttsu_front.sv -----
// front end: command classification and two word queue
`include "periodic_task_tick_scheduler_unit_macros.svh"
module pttsu_front #(
   parameter int SLOTS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [pttsu_pkg::OP_W-1:0]           req_op,
   input  logic [pttsu_pkg::REQ_SLOT_W-1:0]     req_slot,
   input  logic [pttsu_pkg::DELAY_W-1:0]        req_first_delay,
   input  logic [pttsu_pkg::DELAY_W-1:0]        req_period,
   input  logic                                 req_start_running,
   output pttsu_pkg::q_head_type                q_head,
   input  logic                                 q_pop
);
   pttsu_pkg::cmd_type      entry_ff [2];
   logic                    wr_ptr_ff, wr_ptr_in;
   logic                    rd_ptr_ff, rd_ptr_in;
   logic [1:0]              count_ff, count_in;
   pttsu_pkg::cmd_kind_type kind;
   pttsu_pkg::cmd_type      new_cmd;
   logic                    push;

   // classify the incoming word
   always_comb begin
      priority if (req_op == pttsu_pkg::OP_TICK) begin
         kind = pttsu_pkg::K_TICK;
      end else if (req_op > pttsu_pkg::OP_PAUSE) begin
         kind = pttsu_pkg::K_NOP;
      end else if (req_slot >= pttsu_pkg::REQ_SLOT_W'(SLOTS)) begin
         kind = pttsu_pkg::K_RANGE;
      end else if (req_op == pttsu_pkg::OP_CREATE) begin
         kind = pttsu_pkg::K_CREATE;
      end else if (req_op == pttsu_pkg::OP_DELETE) begin
         kind = pttsu_pkg::K_DELETE;
      end else if (req_op == pttsu_pkg::OP_PLAY) begin
         kind = pttsu_pkg::K_PLAY;
      end else begin
         kind = pttsu_pkg::K_PAUSE;
      end
   end

   always_comb begin
      new_cmd.kind          = kind;
      new_cmd.slot          = req_slot[pttsu_pkg::SLOT_W-1:0];
      new_cmd.first_delay   = req_first_delay;
      new_cmd.period        = req_period;
      new_cmd.start_running = req_start_running;
   end

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;

   // queue pointers and fill count
   always_comb begin
      wr_ptr_in = push  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? ~rd_ptr_ff : rd_ptr_ff;
      unique case ({push, q_pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_cmd;
      end
   end

   assign q_head.valid = (count_ff != 2'd0);
   assign q_head.cmd   = entry_ff[rd_ptr_ff];

   `PTTSU_ASSERT_SAME(a_count_bound, 1'b1, count_ff != 2'd3, "queue count overflow")
   `PTTSU_ASSERT_SAME(a_pop_not_empty, q_pop, count_ff != 2'd0, "pop from empty queue")
endmodule

// ----- rtl/pttsu_back.sv -----
// back end: executes commands and walks the slot table on a tick
`include "periodic_task_tick_scheduler_unit_macros.svh"
module pttsu_back #(
   parameter int SLOTS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pttsu_pkg::q_head_type                q_head,
   output logic                                 q_pop,
   output logic                                 rsp_strobe,
   output logic                                 rsp_fired,
   output logic [pttsu_pkg::SLOT_W-1:0]         rsp_fired_slot,
   output logic [pttsu_pkg::STAT_W-1:0]         rsp_status_code,
   output logic                                 rsp_last
);
   localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int DW     = pttsu_pkg::DELAY_W;
   localparam int WORD_W = 2 * DW;

   pttsu_pkg::state_type        state_ff, state_in;
   logic [IDX_W-1:0]            walk_ff, walk_in;
   logic                        p1_vld_ff, p1_vld_in;
   logic [IDX_W-1:0]            p1_idx_ff, p1_idx_in;
   logic [SLOTS-1:0]            occ_ff, occ_in;
   logic [SLOTS-1:0]            run_ff, run_in;
   logic                        strobe_ff, strobe_in;
   logic                        fired_ff, fired_in;
   logic [pttsu_pkg::SLOT_W-1:0] fslot_ff, fslot_in;
   logic [pttsu_pkg::STAT_W-1:0] status_ff, status_in;
   logic                        last_ff, last_in;

   logic                        ram_we;
   logic [IDX_W-1:0]            ram_waddr;
   logic [WORD_W-1:0]           ram_wdata;
   logic [WORD_W-1:0]           ram_rdata;
   logic [DW-1:0]               rd_delay;
   logic [DW-1:0]               rd_period;
   logic [IDX_W-1:0]            cmd_idx;

   // delay and period per slot, period in the upper half
   pttsu_ram #(
      .WIDTH (WORD_W),
      .DEPTH (SLOTS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (walk_ff),
      .rd_data (ram_rdata)
   );

   assign rd_delay  = ram_rdata[DW-1:0];
   assign rd_period = ram_rdata[WORD_W-1:DW];
   assign cmd_idx   = q_head.cmd.slot[IDX_W-1:0];

   // next state, table updates and result word
   always_comb begin
      state_in  = state_ff;
      walk_in   = walk_ff;
      p1_vld_in = 1'b0;
      p1_idx_in = p1_idx_ff;
      occ_in    = occ_ff;
      run_in    = run_ff;
      strobe_in = 1'b0;
      fired_in  = 1'b0;
      fslot_in  = '0;
      status_in = pttsu_pkg::STAT_OK;
      last_in   = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = p1_idx_ff;
      ram_wdata = ram_rdata;
      q_pop     = 1'b0;

      // walk stage: count down, fire and reload one slot
      if (p1_vld_ff && occ_ff[p1_idx_ff]) begin
         if (rd_delay != '0) begin
            ram_we    = 1'b1;
            ram_wdata = {rd_period, rd_delay - DW'(1)};
         end else begin
            if (run_ff[p1_idx_ff]) begin
               strobe_in = 1'b1;
               fired_in  = 1'b1;
               fslot_in  = pttsu_pkg::SLOT_W'(p1_idx_ff);
            end
            if (rd_period != '0) begin
               ram_we    = 1'b1;
               ram_wdata = {rd_period, rd_period - DW'(1)};
            end
         end
      end

      unique case (state_ff)
         pttsu_pkg::ST_IDLE: begin
            if (q_head.valid) begin
               q_pop = 1'b1;
               if (q_head.cmd.kind == pttsu_pkg::K_TICK) begin
                  state_in = pttsu_pkg::ST_WALK;
                  walk_in  = '0;
               end else begin
                  strobe_in = 1'b1;
                  last_in   = 1'b1;
               end
               unique case (q_head.cmd.kind)
                  pttsu_pkg::K_TICK, pttsu_pkg::K_NOP: begin
                  end
                  pttsu_pkg::K_RANGE: begin
                     status_in = pttsu_pkg::STAT_RANGE;
                  end
                  pttsu_pkg::K_CREATE: begin
                     if (occ_ff[cmd_idx]) begin
                        status_in = pttsu_pkg::STAT_SLOT;
                     end else begin
                        occ_in[cmd_idx] = 1'b1;
                        run_in[cmd_idx] = q_head.cmd.start_running;
                        ram_we    = 1'b1;
                        ram_waddr = cmd_idx;
                        ram_wdata = {q_head.cmd.period, q_head.cmd.first_delay};
                     end
                  end
                  pttsu_pkg::K_DELETE: begin
                     if (!occ_ff[cmd_idx]) begin
                        status_in = pttsu_pkg::STAT_SLOT;
                     end else begin
                        occ_in[cmd_idx] = 1'b0;
                     end
                  end
                  pttsu_pkg::K_PLAY: begin
                     if (!occ_ff[cmd_idx]) begin
                        status_in = pttsu_pkg::STAT_SLOT;
                     end else begin
                        run_in[cmd_idx] = 1'b1;
                     end
                  end
                  pttsu_pkg::K_PAUSE: begin
                     if (!occ_ff[cmd_idx]) begin
                        status_in = pttsu_pkg::STAT_SLOT;
                     end else begin
                        run_in[cmd_idx] = 1'b0;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         pttsu_pkg::ST_WALK: begin
            p1_vld_in = 1'b1;
            p1_idx_in = walk_ff;
            if (walk_ff == IDX_W'(SLOTS - 1)) begin
               state_in = pttsu_pkg::ST_FLUSH;
            end else begin
               walk_in = walk_ff + IDX_W'(1);
            end
         end
         pttsu_pkg::ST_FLUSH: begin
            state_in = pttsu_pkg::ST_CLOSE;
         end
         pttsu_pkg::ST_CLOSE: begin
            strobe_in = 1'b1;
            last_in   = 1'b1;
            state_in  = pttsu_pkg::ST_IDLE;
         end
         default: begin
            state_in = pttsu_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= pttsu_pkg::ST_IDLE;
         p1_vld_ff <= 1'b0;
         occ_ff    <= '0;
         run_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         p1_vld_ff <= p1_vld_in;
         occ_ff    <= occ_in;
         run_ff    <= run_in;
         strobe_ff <= strobe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      walk_ff   <= walk_in;
      p1_idx_ff <= p1_idx_in;
      fired_ff  <= fired_in;
      fslot_ff  <= fslot_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign rsp_strobe      = strobe_ff;
   assign rsp_fired       = fired_ff;
   assign rsp_fired_slot  = fslot_ff;
   assign rsp_status_code = status_ff;
   assign rsp_last        = last_ff;

   `PTTSU_ASSERT_SAME(a_close_drained, state_ff == pttsu_pkg::ST_CLOSE, !p1_vld_ff, "walk stage busy at close")
   `PTTSU_ASSERT_SAME(a_flush_last_slot, state_ff == pttsu_pkg::ST_FLUSH, p1_vld_ff && (p1_idx_ff == IDX_W'(SLOTS - 1)), "flush without last slot")
   `PTTSU_ASSERT_NEXT(a_walk_follows, state_ff == pttsu_pkg::ST_WALK, p1_vld_ff && (p1_idx_ff == $past(walk_ff)), "walk stage lost a slot")
endmodule

// ----- rtl/periodic_task_tick_scheduler_unit.sv -----
// Top level of the tick scheduler: front end, command queue and back end.
// A command other than a tick gives a single result word, registered as the back end pops it.
// A tick holds the back end for the walk, one slot table read per cycle, then a
// flush state that drains the table pipeline and a close state for the closing word.
// Commands are taken one per cycle while the two word queue has room.
// Reset empties the slot table; delay and period storage is left as is.
module periodic_task_tick_scheduler_unit #(
   parameter int SLOTS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [pttsu_pkg::OP_W-1:0]           req_op,
   input  logic [pttsu_pkg::REQ_SLOT_W-1:0]     req_slot,
   input  logic [pttsu_pkg::DELAY_W-1:0]        req_first_delay,
   input  logic [pttsu_pkg::DELAY_W-1:0]        req_period,
   input  logic                                 req_start_running,
   output logic                                 rsp_strobe,
   output logic                                 rsp_fired,
   output logic [pttsu_pkg::SLOT_W-1:0]         rsp_fired_slot,
   output logic [pttsu_pkg::STAT_W-1:0]         rsp_status_code,
   output logic                                 rsp_last
);
   pttsu_pkg::q_head_type q_head;
   logic                  q_pop;

   // classify and queue commands
   pttsu_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_slot          (req_slot),
      .req_first_delay   (req_first_delay),
      .req_period        (req_period),
      .req_start_running (req_start_running),
      .q_head            (q_head),
      .q_pop             (q_pop)
   );

   // execute commands and ticks
   pttsu_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_head          (q_head),
      .q_pop           (q_pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_fired       (rsp_fired),
      .rsp_fired_slot  (rsp_fired_slot),
      .rsp_status_code (rsp_status_code),
      .rsp_last        (rsp_last)
   );
endmodule

// ----- bench/tb_periodic_task_tick_scheduler_unit.sv -----
// self-checking testbench for the periodic task tick scheduler
module tb_periodic_task_tick_scheduler_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OP_W         = pttsu_pkg::OP_W;
   localparam int REQ_SLOT_W   = pttsu_pkg::REQ_SLOT_W;
   localparam int DELAY_W      = pttsu_pkg::DELAY_W;
   localparam int SLOT_W       = pttsu_pkg::SLOT_W;
   localparam int STAT_W       = pttsu_pkg::STAT_W;
   localparam int SLOTS        = 16;
   localparam int RESET_CYCLES = 12;
   localparam int MAX_GAP      = 11;
   localparam int RANDOM_ITEMS = 335;
   localparam int LIMIT_CYCLES = 400000;
   localparam int SLOT_MAX     = (1 << REQ_SLOT_W) - 1;
   localparam logic [OP_W-1:0] OP_SPARE_LO = pttsu_pkg::OP_PAUSE + 3'd1;
   localparam logic [OP_W-1:0] OP_SPARE_HI = '1;

   typedef struct {
      logic [OP_W-1:0]       op;
      logic [REQ_SLOT_W-1:0] slot;
      logic [DELAY_W-1:0]    first_delay;
      logic [DELAY_W-1:0]    period;
      logic                  start_running;
      int unsigned           gap;
      bit                    hold;
   } sched_cmd_type;

   typedef struct {
      logic              fired;
      logic [SLOT_W-1:0] fired_slot;
      logic [STAT_W-1:0] status_code;
      logic              last;
   } sched_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [OP_W-1:0]       req_op = pttsu_pkg::OP_TICK;
   logic [REQ_SLOT_W-1:0] req_slot = '0;
   logic [DELAY_W-1:0]    req_first_delay = '0;
   logic [DELAY_W-1:0]    req_period = '0;
   logic                  req_start_running = 1'b0;
   logic                  rsp_strobe;
   logic                  rsp_fired;
   logic [SLOT_W-1:0]     rsp_fired_slot;
   logic [STAT_W-1:0]     rsp_status_code;
   logic                  rsp_last;

   // mirror of the slot table
   bit                 tbl_occupied [SLOTS];
   bit                 tbl_running  [SLOTS];
   logic [DELAY_W-1:0] tbl_delay    [SLOTS];
   logic [DELAY_W-1:0] tbl_period   [SLOTS];

   sched_cmd_type  cmd_queue[$];
   sched_word_type due_words[$];

   int unsigned gap_max = MAX_GAP;
   int unsigned want_count = 0;
   int unsigned want_total = 0;
   int unsigned got_count = 0;
   int unsigned taken_count = 0;
   int unsigned fail_count = 0;
   int unsigned cycle_count = 0;

   periodic_task_tick_scheduler_unit #(
      .SLOTS(SLOTS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_slot(req_slot),
      .req_first_delay(req_first_delay),
      .req_period(req_period),
      .req_start_running(req_start_running),
      .rsp_strobe(rsp_strobe),
      .rsp_fired(rsp_fired),
      .rsp_fired_slot(rsp_fired_slot),
      .rsp_status_code(rsp_status_code),
      .rsp_last(rsp_last)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // apply one accepted word to the table mirror and queue the words it gives
   task automatic advance_slot_table(input sched_cmd_type c);
      sched_word_type w;
      sched_word_type f;
      int             i;
      int             s;
      w.fired       = 1'b0;
      w.fired_slot  = '0;
      w.status_code = pttsu_pkg::STAT_OK;
      w.last        = 1'b1;
      s = int'(c.slot);
      if (c.op == pttsu_pkg::OP_TICK) begin
         for (i = 0; i < SLOTS; i++) begin
            if (tbl_occupied[i]) begin
               if (tbl_delay[i] != 0) begin
                  tbl_delay[i] = tbl_delay[i] - 1'b1;
               end else begin
                  if (tbl_running[i]) begin
                     f.fired       = 1'b1;
                     f.fired_slot  = i[SLOT_W-1:0];
                     f.status_code = pttsu_pkg::STAT_OK;
                     f.last        = 1'b0;
                     due_words.push_back(f);
                     want_count++;
                  end
                  if (tbl_period[i] != 0) tbl_delay[i] = tbl_period[i] - 1'b1;
               end
            end
         end
      end else if (c.op <= pttsu_pkg::OP_PAUSE) begin
         if (s >= SLOTS) begin
            w.status_code = pttsu_pkg::STAT_RANGE;
         end else if (c.op == pttsu_pkg::OP_CREATE) begin
            if (tbl_occupied[s]) begin
               w.status_code = pttsu_pkg::STAT_SLOT;
            end else begin
               tbl_occupied[s] = 1'b1;
               tbl_running[s]  = c.start_running;
               tbl_delay[s]    = c.first_delay;
               tbl_period[s]   = c.period;
            end
         end else if (!tbl_occupied[s]) begin
            w.status_code = pttsu_pkg::STAT_SLOT;
         end else if (c.op == pttsu_pkg::OP_DELETE) begin
            tbl_occupied[s] = 1'b0;
         end else if (c.op == pttsu_pkg::OP_PLAY) begin
            tbl_running[s] = 1'b1;
         end else begin
            tbl_running[s] = 1'b0;
         end
      end
      due_words.push_back(w);
      want_count++;
   endtask

   task automatic queue_cmd(input logic [OP_W-1:0] op, input int slot,
                            input logic [DELAY_W-1:0] first_delay,
                            input logic [DELAY_W-1:0] period, input logic run,
                            input bit hold);
      sched_cmd_type c;
      c.op            = op;
      c.slot          = slot[REQ_SLOT_W-1:0];
      c.first_delay   = first_delay;
      c.period        = period;
      c.start_running = run;
      c.gap           = $urandom_range(0, gap_max);
      c.hold          = hold;
      cmd_queue.push_back(c);
   endtask

   // request driver: one word on the port at a time, gaps drawn per word
   always @(posedge clock) begin : drv
      sched_cmd_type on_port;
      sched_cmd_type staged;
      bit            staged_ok;
      bit            go;
      int unsigned   idle_left;
      if (reset) begin
         start <= 1'b0;
         staged_ok = 1'b0;
         idle_left = 0;
      end else begin
         go = 1'b0;
         if (start && !busy) begin
            advance_slot_table(on_port);
            taken_count <= taken_count + 1;
            want_total  <= want_count;
         end
         if (!start || !busy) begin
            if (!staged_ok && cmd_queue.size() != 0) begin
               staged    = cmd_queue.pop_front();
               staged_ok = 1'b1;
               idle_left = staged.gap;
            end
            if (staged_ok) begin
               if (idle_left != 0) idle_left--;
               else if (!staged.hold || want_count == got_count) go = 1'b1;
            end
            if (go) begin
               start             <= 1'b1;
               req_op            <= staged.op;
               req_slot          <= staged.slot;
               req_first_delay   <= staged.first_delay;
               req_period        <= staged.period;
               req_start_running <= staged.start_running;
               on_port   = staged;
               staged_ok = 1'b0;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // result monitor: each strobed word against the oldest expected word
   always @(posedge clock) begin : mon
      sched_word_type w;
      int unsigned    bad;
      if (!reset && rsp_strobe) begin
         if (due_words.size() == 0) begin
            $error("result word with nothing expected");
            fail_count <= fail_count + 1;
         end else begin
            w   = due_words.pop_front();
            bad = 0;
            if (rsp_fired !== w.fired) begin
               $error("fired: expected %0d, got %0d", w.fired, rsp_fired);
               bad++;
            end
            if (rsp_fired_slot !== w.fired_slot) begin
               $error("fired_slot: expected %0d, got %0d", w.fired_slot, rsp_fired_slot);
               bad++;
            end
            if (rsp_status_code !== w.status_code) begin
               $error("status_code: expected %0d, got %0d", w.status_code,
                      rsp_status_code);
               bad++;
            end
            if (rsp_last !== w.last) begin
               $error("last: expected %0d, got %0d", w.last, rsp_last);
               bad++;
            end
            fail_count <= fail_count + bad;
            got_count  <= got_count + 1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("[periodic_task_tick_scheduler_unit] ERROR");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin : stim
      logic [OP_W-1:0]    op;
      int                 sl;
      logic [DELAY_W-1:0] fd;
      logic [DELAY_W-1:0] per;
      logic               run;
      bit                 hold;
      int                 pick;
      int                 k;
      int unsigned        n_items;

      // directed: empty table, extremes, every error path, pause and play
      queue_cmd(pttsu_pkg::OP_TICK,   0,   '0, '0, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_CREATE, 0,   '0, '0, 1'b1, 1'b0);
      queue_cmd(pttsu_pkg::OP_CREATE, SLOTS - 1, '1, '1, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_CREATE, 0,   16'h1234, 16'h0005, 1'b1, 1'b0);
      queue_cmd(pttsu_pkg::OP_CREATE, SLOTS, '0, '0, 1'b1, 1'b0);
      queue_cmd(pttsu_pkg::OP_CREATE, SLOT_MAX, '1, '1, 1'b1, 1'b0);
      queue_cmd(pttsu_pkg::OP_DELETE, 5,   '0, '0, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_PLAY,   6,   '0, '0, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_PAUSE,  7,   '0, '0, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_CREATE, 3,   16'd1, 16'd2, 1'b1, 1'b0);
      queue_cmd(pttsu_pkg::OP_TICK,   SLOT_MAX, '1, '1, 1'b1, 1'b0);
      queue_cmd(pttsu_pkg::OP_TICK,   0,   '0, '0, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_PAUSE,  0,   '0, '0, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_TICK,   0,   '0, '0, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_PLAY,   SLOTS - 1, '0, '0, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_PLAY,   0,   '0, '0, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_TICK,   0,   '0, '0, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_DELETE, 3,   '0, '0, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_CREATE, 3,   '0, 16'd1, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_PLAY,   3,   '0, '0, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_TICK,   0,   '0, '0, 1'b0, 1'b0);
      queue_cmd(OP_SPARE_LO, 2, '1, '0, 1'b1, 1'b0);
      queue_cmd(OP_SPARE_HI, SLOT_MAX, '0, '1, 1'b0, 1'b0);
      queue_cmd(OP_SPARE_LO + 3'd1, 4, 16'hA5A5, 16'h5A5A, 1'b1, 1'b0);
      queue_cmd(pttsu_pkg::OP_PAUSE,  200, '0, '0, 1'b0, 1'b0);
      queue_cmd(pttsu_pkg::OP_DELETE, SLOTS - 1, '0, '0, 1'b0, 1'b0);

      // random: mostly valid slots with short delays so tasks fire often
      for (k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 24 == 0) gap_max = ($urandom_range(0, 2) == 0) ? 0 : MAX_GAP;
         pick = int'($urandom_range(0, 99));
         sl   = int'($urandom_range(0, SLOTS - 1));
         fd   = ($urandom_range(0, 7) == 0) ? DELAY_W'($urandom)
                                            : DELAY_W'($urandom_range(0, 4));
         per  = ($urandom_range(0, 7) == 0) ? DELAY_W'($urandom)
                                            : DELAY_W'($urandom_range(0, 5));
         run  = 1'($urandom_range(0, 1));
         hold = (k == 0) || ($urandom_range(0, 29) == 0);
         if (pick < 25) begin
            op = pttsu_pkg::OP_TICK;
            sl = int'($urandom_range(0, SLOT_MAX));
         end else if (pick < 55) begin
            op = pttsu_pkg::OP_CREATE;
         end else if (pick < 67) begin
            op = pttsu_pkg::OP_DELETE;
         end else if (pick < 79) begin
            op = pttsu_pkg::OP_PLAY;
         end else if (pick < 91) begin
            op = pttsu_pkg::OP_PAUSE;
         end else if (pick < 96) begin
            op = OP_W'($urandom_range(pttsu_pkg::OP_CREATE, pttsu_pkg::OP_PAUSE));
            sl = int'($urandom_range(SLOTS, SLOT_MAX));
         end else begin
            op = OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
            sl = int'($urandom_range(0, SLOT_MAX));
         end
         queue_cmd(op, sl, fd, per, run, hold);
      end
      n_items = cmd_queue.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (taken_count != n_items) @(posedge clock);
      while (got_count != want_total) @(posedge clock);
      repeat (SLOTS + 8) @(posedge clock);

      if (fail_count == 0 && due_words.size() == 0) begin
         $display("[periodic_task_tick_scheduler_unit] OK");
      end else begin
         $display("[periodic_task_tick_scheduler_unit] ERROR");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/pttsu_pkg.sv
rtl/pttsu_ram.sv
rtl/pttsu_front.sv
rtl/pttsu_back.sv
rtl/periodic_task_tick_scheduler_unit.sv
bench/tb_periodic_task_tick_scheduler_unit.sv
